>>> hw/rtl/set_pkg.sv
// Shared types, constants and functions for the Sobel edge threshold block.
// No dependencies.
package set_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 65536;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int PixW      = 24;

  localparam logic [7:0] WeightRed   = 8'd77;
  localparam logic [7:0] WeightGreen = 8'd150;
  localparam logic [7:0] WeightBlue  = 8'd29;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_THRESH = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_BOTH  = 2'd0,
    MODE_FIRST = 2'd1,
    MODE_SECOND = 2'd2,
    MODE_ALIAS = 2'd3
  } grad_mode_t;

  // Control handed from the line store stage to the gradient stage.
  typedef struct packed {
    logic            vld;
    logic            interior;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } win_ctl_t;

  // Extract one 8-bit channel from a packed pixel.
  function automatic logic [7:0] chan(input logic [PixW-1:0] p, input int c);
    chan = p[8*c +: 8];
  endfunction

endpackage

>>> hw/rtl/sobel_edge_threshold.sv
// Streaming 3x3 Sobel edge detector with gray threshold. One pixel is
// accepted per clock while the output is not stalled; a result for an
// interior pixel is produced from the pixel that completes its window
// through the gradient stages and the 17-stage square root pipeline. Two
// 4096x24 line stores are read and written back at the same column each
// pixel. The whole pipeline holds while out_valid and out_stall are both high.
module sobel_edge_threshold (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_frame_start,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_centre_col,
  output logic [15:0] out_centre_row,
  output logic [22:0] out_weighted_gradient_q12,
  output logic [7:0]  out_edge_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [22:0] cfg_data
);
  logic [1:0]  mode_r;
  logic [12:0] width_r;
  logic [16:0] height_r;
  logic [22:0] thresh_r;
  logic adv;
  set_pkg::win_ctl_t ctl;
  logic [set_pkg::PixW-1:0] win [9];
  logic res_vld;
  logic [11:0] res_col;
  logic [15:0] res_row;
  logic [22:0] res_sum;
  logic [7:0]  res_edge;

  assign cfg_ready = 1'b1;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = res_vld;
  assign out_centre_col = res_col;
  assign out_centre_row = res_row;
  assign out_weighted_gradient_q12 = res_sum;
  assign out_edge_value = res_edge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
      width_r <= 13'd640;
      height_r <= 17'd480;
      thresh_r <= 23'd522240;
    end else if (cfg_valid) begin
      unique case (set_pkg::cfg_idx_t'(cfg_index))
        set_pkg::CFG_MODE:   mode_r <= cfg_data[1:0];
        set_pkg::CFG_WIDTH:  width_r <= cfg_data[12:0];
        set_pkg::CFG_HEIGHT: height_r <= cfg_data[16:0];
        set_pkg::CFG_THRESH: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  set_line_store u_ls (
    .clk(clk), .rst_n(rst_n), .adv(adv), .px_vld(in_valid),
    .px_start(in_frame_start), .px({in_blue, in_green, in_red}),
    .width(width_r), .height(height_r), .ctl(ctl), .win(win)
  );

  set_gradient u_grad (
    .clk(clk), .rst_n(rst_n), .adv(adv), .ctl(ctl), .win(win),
    .mode(mode_r), .thresh(thresh_r), .res_vld(res_vld), .res_col(res_col),
    .res_row(res_row), .res_sum(res_sum), .res_edge(res_edge)
  );

  a_edge_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_edge_value == 8'd255 || out_edge_value == 8'd0))
    else $error("edge value not binary");
  a_edge_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_edge_value == 8'd255) == (out_weighted_gradient_q12 > thresh_r)))
    else $error("edge decision mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_weighted_gradient_q12))
    else $error("stalled result changed");
endmodule

>>> hw/rtl/set_line_store.sv
// Line stores (two synchronous memories) and the 3x3 window shift registers.
// Depends on set_pkg.
module set_line_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         px_vld,
  input  logic                         px_start,
  input  logic [set_pkg::PixW-1:0]     px,
  input  logic [12:0]                  width,
  input  logic [16:0]                  height,
  output set_pkg::win_ctl_t            ctl,
  output logic [set_pkg::PixW-1:0]     win [9]
);
  localparam int CW = set_pkg::ColW;
  localparam int RW = set_pkg::RowW;

  logic [set_pkg::PixW-1:0] upper_mem [set_pkg::MaxWidth];
  logic [set_pkg::PixW-1:0] middle_mem [set_pkg::MaxWidth];

  logic [CW:0] col_r, col_nxt;
  logic [RW:0] row_r, row_nxt;
  logic [CW:0] ew;
  logic [RW:0] eh;
  logic [CW:0] c0;
  logic [RW:0] r0;
  logic [CW-1:0] addr;

  // stage 1: address issued, read pending
  logic                     s1_vld_r;
  logic [set_pkg::PixW-1:0] s1_pix_r;
  logic [CW-1:0]            s1_col_r;
  logic [RW-1:0]            s1_row_r;
  logic [set_pkg::PixW-1:0] up_q_r, mid_q_r;
  logic [set_pkg::PixW-1:0] win_r [9];
  set_pkg::win_ctl_t        ctl_r;

  always_comb begin
    ew = (width == 13'd0) ? (CW+1)'(1) :
         (width > 13'(set_pkg::MaxWidth)) ? (CW+1)'(set_pkg::MaxWidth) : width[CW:0];
    eh = (height == 17'd0) ? (RW+1)'(1) :
         (height > 17'(set_pkg::MaxHeight)) ? (RW+1)'(set_pkg::MaxHeight) : height[RW:0];
    c0 = px_start ? '0 : col_r;
    r0 = px_start ? '0 : row_r;
    if (c0 >= ew) begin
      c0 = '0;
      r0 = r0 + 1'b1;
    end
    if (r0 >= eh) r0 = '0;
    addr    = c0[CW-1:0];
    col_nxt = c0 + 1'b1;
    row_nxt = r0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_vld_r <= 1'b0;
      ctl_r <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (adv) begin
      s1_vld_r <= px_vld;
      if (px_vld) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      ctl_r.vld <= s1_vld_r;
      ctl_r.col <= s1_col_r - 1'b1;
      ctl_r.row <= s1_row_r - 1'b1;
      ctl_r.interior <= (s1_col_r >= CW'(2)) && (s1_row_r >= RW'(2));
      if (s1_vld_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]   <= win_r[r*3+1];
          win_r[r*3+1] <= win_r[r*3+2];
        end
        win_r[2] <= up_q_r;
        win_r[5] <= mid_q_r;
        win_r[8] <= s1_pix_r;
      end
    end
  end

  // Each access reads and writes back its column together, so a later access
  // to the same address (a one-column frame or a restart) sees the new contents.
  always_ff @(posedge clk) begin
    if (adv && px_vld) begin
      up_q_r  <= upper_mem[addr];
      mid_q_r <= middle_mem[addr];
      upper_mem[addr]  <= middle_mem[addr];
      middle_mem[addr] <= px;
      s1_pix_r <= px;
      s1_col_r <= addr;
      s1_row_r <= r0[RW-1:0];
    end
  end

  assign ctl = ctl_r;
  assign win = win_r;
endmodule

>>> hw/rtl/set_isqrt.sv
// Pipelined integer square root, one result bit per stage (17 stages).
// No dependencies; set_pkg is not referenced.
module set_isqrt (
  input  logic        clk,
  input  logic        adv,
  input  logic [32:0] val,
  output logic [16:0] root
);
  localparam int N = 17;
  logic [33:0] rem_r [1:N];
  logic [16:0] rt_r  [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [33:0] rem_in;
    logic [16:0] rt_in;
    logic [16:0] trial;
    logic [33:0] sq;
    if (i == 0) begin : g_head
      assign rem_in = {1'b0, val};
      assign rt_in  = '0;
    end else begin : g_body
      assign rem_in = rem_r[i];
      assign rt_in  = rt_r[i];
    end
    always_comb begin
      trial = rt_in | (17'd1 << (N-1-i));
      sq    = 34'(trial) * 34'(trial);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i+1] <= rem_in;
        rt_r[i+1]  <= (sq <= rem_in) ? trial : rt_in;
      end
    end
  end

  assign root = rt_r[N];
endmodule

>>> hw/rtl/set_gradient.sv
// Sobel sums, magnitude, channel weighting and threshold compare.
// Depends on set_pkg and set_isqrt.
module set_gradient (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  set_pkg::win_ctl_t        ctl,
  input  logic [set_pkg::PixW-1:0] win [9],
  input  logic [1:0]               mode,
  input  logic [22:0]              thresh,
  output logic                     res_vld,
  output logic [11:0]              res_col,
  output logic [15:0]              res_row,
  output logic [22:0]              res_sum,
  output logic [7:0]               res_edge
);
  localparam int D = 20; // delay: abs stage + square + sqrt (17) + sum

  logic [10:0] ax_r [3], ay_r [3];
  logic [21:0] sqx_r [3], sqy_r [3];
  logic [10:0] ax2_r [3], ay2_r [3];
  logic [16:0] root [3];
  logic [10:0] ax_d [D-3][3], ay_d [D-3][3];
  set_pkg::win_ctl_t ctl_d [D];
  logic [1:0] mode_q;
  logic [14:0] mag [3];
  logic [22:0] sum_r;
  logic [7:0] wt [3];

  assign wt[0] = set_pkg::WeightRed;
  assign wt[1] = set_pkg::WeightGreen;
  assign wt[2] = set_pkg::WeightBlue;
  assign mode_q = mode;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic signed [11:0] gx, gy;
    logic [11:0] p [9];
    always_comb begin
      for (int k = 0; k < 9; k++) p[k] = {4'd0, set_pkg::chan(win[k], c)};
      gx = $signed(p[0] + (p[1] << 1) + p[2]) - $signed(p[6] + (p[7] << 1) + p[8]);
      gy = $signed(p[2] + (p[5] << 1) + p[8]) - $signed(p[0] + (p[3] << 1) + p[6]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ax_r[c]  <= gx[11] ? 11'(-gx) : gx[10:0];
        ay_r[c]  <= gy[11] ? 11'(-gy) : gy[10:0];
        sqx_r[c] <= 22'(ax_r[c]) * 22'(ax_r[c]);
        sqy_r[c] <= 22'(ay_r[c]) * 22'(ay_r[c]);
        ax2_r[c] <= ax_r[c];
        ay2_r[c] <= ay_r[c];
      end
    end
    set_isqrt u_sqrt (
      .clk (clk),
      .adv (adv),
      .val ({(33'(sqx_r[c]) + 33'(sqy_r[c]))} << 8),
      .root(root[c])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        ax_d[0][c] <= ax2_r[c];
        ay_d[0][c] <= ay2_r[c];
        for (int k = 1; k < D-3; k++) begin
          ax_d[k][c] <= ax_d[k-1][c];
          ay_d[k][c] <= ay_d[k-1][c];
        end
      end
    end
    always_comb begin
      if (mode_q == set_pkg::MODE_FIRST)       mag[c] = {ax_d[16][c], 4'd0};
      else if (mode_q == set_pkg::MODE_SECOND) mag[c] = {ay_d[16][c], 4'd0};
      else                                     mag[c] = root[c][14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < D; k++) ctl_d[k] <= '0;
    end else if (adv) begin
      ctl_d[0] <= ctl;
      for (int k = 1; k < D; k++) ctl_d[k] <= ctl_d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= 23'(23'(mag[0]) * 23'(wt[0]) + 23'(mag[1]) * 23'(wt[1])
                 + 23'(mag[2]) * 23'(wt[2]));
    end
  end

  assign res_vld  = ctl_d[D-1].vld && ctl_d[D-1].interior;
  assign res_col  = ctl_d[D-1].col;
  assign res_row  = ctl_d[D-1].row;
  assign res_sum  = sum_r;
  assign res_edge = (sum_r > thresh) ? 8'd255 : 8'd0;
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for sobel_edge_threshold: drives RGB frames, predicts each interior
// edge decision and checks results in order. Depends on set_pkg.
module tb;

  localparam int CycleLimit = 1000000;
  localparam int DrainWait  = 40;

  typedef struct packed {
    logic [11:0] col;
    logic [15:0] row;
    logic [22:0] grad;
    logic [7:0]  edge_val;
  } decision_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_frame_start = 1'b0;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_centre_col;
  logic [15:0] out_centre_row;
  logic [22:0] out_weighted_gradient_q12;
  logic [7:0]  out_edge_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [22:0] cfg_data = '0;

  sobel_edge_threshold i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [23:0] row_above [set_pkg::MaxWidth];
  logic [23:0] row_mid   [set_pkg::MaxWidth];
  logic [23:0] win [9];
  int unsigned pos_col, pos_row;
  set_pkg::grad_mode_t mode_q;
  int unsigned width_q, height_q, thresh_q;

  decision_t pending_decisions [$];
  int  errors = 0;
  int  cycles = 0;
  int  pixels_sent = 0;
  bit  no_gaps = 1'b0;
  int  long_hold = 0;

  function automatic int unsigned floor_sqrt(int unsigned v);
    int unsigned root, b;
    root = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic int px(logic [23:0] p, int c);
    return int'(p[8*c +: 8]);
  endfunction

  function automatic void predict_decision(bit fs, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b);
    int unsigned ew, eh, here, total, mag, ax, ay;
    int gx, gy;
    int unsigned wt [3];
    logic [23:0] p, up, mid;
    decision_t d;
    wt[0] = set_pkg::WeightRed;
    wt[1] = set_pkg::WeightGreen;
    wt[2] = set_pkg::WeightBlue;
    ew = (width_q == 0) ? 1 :
         (width_q > set_pkg::MaxWidth ? set_pkg::MaxWidth : width_q);
    eh = (height_q == 0) ? 1 :
         (height_q > set_pkg::MaxHeight ? set_pkg::MaxHeight : height_q);
    if (fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    if (pos_col >= ew) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= eh) pos_row = 0;
    p = {b, g, r};
    up = row_above[pos_col];
    mid = row_mid[pos_col];
    row_above[pos_col] = mid;
    row_mid[pos_col] = p;
    for (int k = 0; k < 3; k++) begin
      win[3*k] = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = p;
    here = pos_col;
    pos_col++;
    if (here < 2 || pos_row < 2) return;
    total = 0;
    for (int c = 0; c < 3; c++) begin
      gx = px(win[0], c) + 2 * px(win[1], c) + px(win[2], c)
         - px(win[6], c) - 2 * px(win[7], c) - px(win[8], c);
      gy = -px(win[0], c) + px(win[2], c) - 2 * px(win[3], c) + 2 * px(win[5], c)
         - px(win[6], c) + px(win[8], c);
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      if (mode_q == set_pkg::MODE_FIRST) mag = ax << 4;
      else if (mode_q == set_pkg::MODE_SECOND) mag = ay << 4;
      else mag = floor_sqrt((ax * ax + ay * ay) << 8);
      total += mag * wt[c];
    end
    total &= 32'h7F_FFFF;
    d.col = 12'(here - 1);
    d.row = 16'(pos_row - 1);
    d.grad = 23'(total);
    d.edge_val = (total > thresh_q) ? 8'd255 : 8'd0;
    pending_decisions.push_back(d);
  endfunction

  task automatic send_pixel(bit fs, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_frame_start <= fs;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_decision(fs, r, g, b);
    pixels_sent++;
  endtask

  // wait for all decisions, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(set_pkg::cfg_idx_t idx, int unsigned value);
    cfg_index <= idx;
    cfg_data <= 23'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      set_pkg::CFG_MODE:   mode_q = set_pkg::grad_mode_t'(value[1:0]);
      set_pkg::CFG_WIDTH:  width_q = value & 32'h1FFF;
      set_pkg::CFG_HEIGHT: height_q = value & 32'h1_FFFF;
      set_pkg::CFG_THRESH: thresh_q = value & 32'h7F_FFFF;
      default: ;
    endcase
  endtask

  task automatic setup(int unsigned m, int unsigned w, int unsigned h, int unsigned t);
    wait_idle();
    write_reg(set_pkg::CFG_MODE, m);
    write_reg(set_pkg::CFG_WIDTH, w);
    write_reg(set_pkg::CFG_HEIGHT, h);
    write_reg(set_pkg::CFG_THRESH, t);
    cfg_valid <= 1'b0;
  endtask

  // noisy frames get a stray restart now and then
  task automatic send_frame(int w, int h, bit lead_fs, bit noisy);
    bit fs;
    for (int i = 0; i < w * h; i++) begin
      fs = (i == 0 && lead_fs) || (noisy && $urandom_range(0, 39) == 0);
      send_pixel(fs, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_extremes();
    setup(set_pkg::MODE_BOTH, 3, 3, 0);
    // hard vertical edge, full contrast on every channel
    for (int i = 0; i < 9; i++)
      send_pixel(i == 0, (i % 3 == 0) ? 8'd0 : 8'd255, (i % 3 == 0) ? 8'd0 : 8'd255,
                 (i % 3 == 0) ? 8'd0 : 8'd255);
    setup(set_pkg::MODE_FIRST, 3, 3, 23'h7F_FFFF);
    for (int i = 0; i < 9; i++)
      send_pixel(i == 0, (i < 3) ? 8'd255 : 8'd0, (i < 3) ? 8'd255 : 8'd0,
                 (i < 3) ? 8'd255 : 8'd0);
    setup(set_pkg::MODE_SECOND, 0, 0, 1000);
    repeat (3) send_pixel(1'b1, 8'd255, 8'd0, 8'd255);
    setup(set_pkg::MODE_ALIAS, 1, 65536, 1000);
    repeat (3) send_pixel(1'b0, 8'd17, 8'd200, 8'd3);
  endtask

  task automatic test_modes();
    for (int m = 0; m < 4; m++) begin
      setup(m, 3 + m, 3, $urandom_range(0, 3000000));
      send_frame(3 + m, 3, 1'b1, 1'b0);
    end
  endtask

  // clamped width: a partial first row gives no decisions
  task automatic test_wide_frame();
    setup(set_pkg::MODE_BOTH, 8191, 3, 1500000);
    send_frame(200, 1, 1'b1, 1'b0);
  endtask

  task automatic test_backpressure();
    setup(set_pkg::MODE_BOTH, 10, 8, 1500000);
    no_gaps = 1'b1;
    long_hold = 400;
    send_frame(10, 8, 1'b1, 1'b0);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_frames();
    int w, h;
    while (pixels_sent < 750) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 6);
      setup($urandom_range(0, 3), w, h,
            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 23'h7F_FFFF)
                                        : $urandom_range(0, 3000000));
      no_gaps = ($urandom_range(0, 3) == 0);
      // a new geometry always starts on a frame boundary
      send_frame(w, h, 1'b1, $urandom_range(0, 4) == 0);
      repeat ($urandom_range(0, 2))
        send_frame(w, h, $urandom_range(0, 4) != 0, $urandom_range(0, 4) == 0);
    end
    no_gaps = 1'b0;
  endtask

  // result side stall pattern
  initial begin
    int n;
    forever begin
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
      end else begin
        n = no_gaps ? 0 : $urandom_range(0, 5);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    decision_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decisions.size() == 0) begin
        $display("%0t: unexpected transfer col %0d row %0d", $time, out_centre_col,
                 out_centre_row);
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        if (out_centre_col !== want.col) begin
          $display("%0t: col expected %0d actual %0d", $time, want.col, out_centre_col);
          errors++;
        end
        if (out_centre_row !== want.row) begin
          $display("%0t: row expected %0d actual %0d", $time, want.row, out_centre_row);
          errors++;
        end
        if (out_weighted_gradient_q12 !== want.grad) begin
          $display("%0t: gradient expected %0d actual %0d", $time, want.grad,
                   out_weighted_gradient_q12);
          errors++;
        end
        if (out_edge_value !== want.edge_val) begin
          $display("%0t: edge expected %0d actual %0d", $time, want.edge_val,
                   out_edge_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("sobel_edge_threshold verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < set_pkg::MaxWidth; i++) begin
      row_above[i] = '0;
      row_mid[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    pos_col = 0;
    pos_row = 0;
    mode_q = set_pkg::MODE_BOTH;
    width_q = 640;
    height_q = 480;
    thresh_q = 522240;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_modes();
    test_backpressure();
    test_wide_frame();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("sobel_edge_threshold verification clean");
    end else begin
      $display("sobel_edge_threshold verification failed");
    end
    $finish;
  end

endmodule
